[rtl/simplex_projection_assert.svh]
// assertion helpers for the simplex projection block
`ifndef SIMPLEX_PROJECTION_ASSERT_SVH
`define SIMPLEX_PROJECTION_ASSERT_SVH
// property that must hold at every rising clock edge outside reset
`define SP_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/sp_pkg.sv]
package sp_pkg;
    // one stored element plus its last flag, passed through the queue
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_elem;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OUT_W   = 31;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
endpackage

[rtl/sp_fifo.sv]
module sp_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sp_pkg::t_elem i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sp_pkg::t_elem o_data
);
    import sp_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_elem          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage, written without reset
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop && !o_empty)
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

[rtl/sp_core.sv]
module sp_core #(
    parameter int unsigned MAX_LEN   = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  sp_pkg::t_elem          i_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [sp_pkg::OUT_W-1:0] o_value,
    output logic                   o_last,
    output logic                   o_too_long
);
    import sp_pkg::*;
    localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned SW = VALUE_W + CW + 1;
    localparam int unsigned TW = VALUE_W + 2;
    localparam logic [1:0] ST_LOAD = 2'd0, ST_SORT = 2'd1, ST_SCAN = 2'd2, ST_EMIT = 2'd3;

    logic [1:0]               r_state, n_state;
    logic signed [31:0]       r_elem [MAX_LEN];
    logic signed [31:0]       r_srt  [MAX_LEN];
    logic [CW-1:0]            r_cnt;
    logic [CW-1:0]            r_idx;
    logic                     r_ovf;
    logic signed [SW-1:0]     r_sum;
    logic signed [TW-1:0]     r_thr;
    // divider state
    logic                     r_dbusy;
    logic [SW-1:0]            r_num;
    logic [SW-1:0]            r_rem;
    logic [SW-1:0]            r_quo;
    logic [$clog2(SW+1)-1:0]  r_dstep;
    logic                     r_dneg;
    logic [CW-1:0]            r_den;
    logic signed [31:0]       r_key;
    logic                     r_dfix;
    // output register
    logic                     r_ov;
    logic [OUT_W-1:0]         r_oval;
    logic                     r_olast, r_otl;

    assign o_valid    = r_ov;
    assign o_value    = r_oval;
    assign o_last     = r_olast;
    assign o_too_long = r_otl;
    assign o_pop      = (r_state == ST_LOAD) && !i_empty;

    // odd-even transposition sort step over the filled part of the row, one pass a cycle
    logic signed [31:0] w_sorted [MAX_LEN];
    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) w_sorted[k] = r_srt[k];
        for (int k = 0; k + 1 < MAX_LEN; k++) begin
            if ((k % 2) == int'(r_idx[0]) && (k + 1) < int'(r_cnt)
                && r_srt[k] < r_srt[k+1]) begin
                w_sorted[k]   = r_srt[k+1];
                w_sorted[k+1] = r_srt[k];
            end
        end
    end

    logic signed [SW-1:0] w_num;
    logic [SW-1:0]        w_mag;
    logic [SW-1:0]        w_trial;
    logic signed [SW+1:0] w_q;
    logic signed [TW:0]   w_diff;
    logic signed [TW:0]   w_d;
    logic signed [31:0]   w_cur;
    assign w_cur   = r_srt[r_idx[IW-1:0]];
    assign w_num   = r_sum + SW'(w_cur) - SW'(64'sd1 <<< FRAC_BITS);
    assign w_mag   = w_num[SW-1] ? SW'(-w_num) : SW'(w_num);
    assign w_trial = {r_rem[SW-2:0], r_num[SW-1]};
    // floor quotient: negate magnitude quotient, step down if remainder nonzero
    assign w_q     = r_dneg ? (-(SW+2)'($signed({2'b0, r_quo})) - (SW+2)'(r_rem != '0))
                            : (SW+2)'($signed({2'b0, r_quo}));
    assign w_diff  = (TW+1)'(r_key) - (TW+1)'(w_q);
    assign w_d     = (TW+1)'(r_elem[r_idx[IW-1:0]]) - (TW+1)'(r_thr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (o_pop && i_data.last) n_state = ST_SORT;
            ST_SORT: if (r_idx == r_cnt) n_state = ST_SCAN;
            ST_SCAN: if (!r_dbusy && !r_dfix && r_idx == r_cnt) n_state = ST_EMIT;
            ST_EMIT: if ((!r_ov || i_ready) && r_idx == r_cnt) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // element store and sort row
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && o_pop && r_cnt < CW'(MAX_LEN))
            r_elem[r_cnt[IW-1:0]] <= i_data.value;
        if (r_state == ST_LOAD && o_pop && i_data.last) begin
            for (int k = 0; k < MAX_LEN; k++)
                r_srt[k] <= (k == int'(r_cnt) && r_cnt < CW'(MAX_LEN)) ? i_data.value : r_elem[k];
        end else if (r_state == ST_SORT) begin
            for (int k = 0; k < MAX_LEN; k++) r_srt[k] <= w_sorted[k];
        end
    end

    // sequencer, threshold scan with shared divider, output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_cnt <= '0; r_idx <= '0; r_ovf <= 1'b0;
            r_sum <= '0; r_thr <= '0; r_dbusy <= 1'b0; r_dfix <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (o_pop) begin
                        if (r_cnt < CW'(MAX_LEN)) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                        if (i_data.last) r_idx <= '0;
                    end
                end
                ST_SORT: begin
                    if (r_idx == r_cnt) begin
                        r_idx <= '0; r_sum <= '0; r_thr <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_dfix) begin
                        r_dfix <= 1'b0;
                        if (w_diff > 0) r_thr <= TW'(w_q);
                        r_idx <= r_idx + 1'b1;
                    end else if (r_dbusy) begin
                        // restoring division, one quotient bit a cycle
                        r_num <= {r_num[SW-2:0], 1'b0};
                        if (w_trial >= SW'(r_den)) begin
                            r_rem <= w_trial - SW'(r_den);
                            r_quo <= {r_quo[SW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[SW-2:0], 1'b0};
                        end
                        r_dstep <= r_dstep - 1'b1;
                        if (r_dstep == 1) begin
                            r_dbusy <= 1'b0; r_dfix <= 1'b1;
                        end
                    end else if (r_idx != r_cnt) begin
                        r_sum   <= r_sum + SW'(w_cur);
                        r_num   <= w_mag;
                        r_dneg  <= w_num[SW-1];
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_den   <= r_idx + 1'b1;
                        r_key   <= w_cur;
                        r_dstep <= ($clog2(SW+1))'(SW);
                        r_dbusy <= 1'b1;
                    end else begin
                        r_idx <= '0;
                    end
                end
                ST_EMIT: begin
                    if ((!r_ov || i_ready) && r_idx != r_cnt) begin
                        r_ov    <= 1'b1;
                        r_oval  <= w_d[TW] ? '0 : ((w_d > (TW+1)'(OUT_MAX)) ? OUT_MAX
                                                                           : OUT_W'(w_d));
                        r_olast <= (r_idx + 1'b1 == r_cnt);
                        r_otl   <= r_ovf;
                        r_idx   <= r_idx + 1'b1;
                    end
                    if ((!r_ov || i_ready) && r_idx == r_cnt) begin
                        r_cnt <= '0; r_ovf <= 1'b0; r_idx <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/simplex_projection.sv]
// simplex_projection: projects a vector onto the probability simplex
// input channel (s_axis): one signed fixed-point component per transaction,
//   tlast marks the final component of a vector
// output channel (m_axis): one projected component per transaction in input
//   order; tlast on the final one, tuser set when the vector held more than
//   MAX_LEN components (the excess is dropped, the kept ones are projected)
// a 4-entry queue decouples intake from the projection engine; the engine
// loads, sorts with one odd-even pass a cycle, scans the prefix sums with a
// shared restoring divider that works through the components in turn, and
// emits one result a cycle while tready is high; the serial divider
// dominates the time a vector spends in the engine, and the engine loads
// the next vector only after the last result of the current one is emitted
// the output is held in a register while tready is low; the engine and then
// the queue stall behind it
// reset (synchronous, active low) empties the queue and returns to loading
module simplex_projection #(
    parameter int unsigned MAX_LEN   = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element_value
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // projected_value, zero pad bit
    output logic        m_axis_tlast,   // last_out
    output logic        m_axis_tuser    // too_long
);
    import sp_pkg::*;
    `include "simplex_projection_assert.svh"

    t_elem w_in, w_q;
    logic  w_full, w_empty, w_pop;
    logic [OUT_W-1:0] w_val;

    assign w_in.value    = s_axis_tdata;
    assign w_in.last     = s_axis_tlast;
    assign s_axis_tready = !w_full;
    assign m_axis_tdata  = {1'b0, w_val};

    sp_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_push(s_axis_tvalid), .i_data(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_q)
    );

    sp_core #(.MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_data(w_q), .o_pop(w_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_value(w_val),
        .o_last(m_axis_tlast), .o_too_long(m_axis_tuser)
    );

    `SP_ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(w_pop && w_empty))
    `SP_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
